>>> rtl/core/stge_pkg.sv
// ----------------------------------------------------------------------------
// stge_pkg: shared constants and types of the stabilizer tableau gate engine
// ----------------------------------------------------------------------------
package stge_pkg;

   localparam int MaxQubits      = 256;
   localparam int WordBits       = 64;
   localparam int WordsPerColumn = 4;
   localparam int QubitBits      = $clog2(MaxQubits);
   localparam int WordIdxBits    = $clog2(WordsPerColumn);
   localparam int AddrBits       = QubitBits + WordIdxBits;
   localparam int CountBits      = QubitBits + 1;

   typedef logic [WordBits-1:0] word_type;

   localparam logic [2:0] REQ_GATE  = 3'd0;
   localparam logic [2:0] REQ_READX = 3'd1;
   localparam logic [2:0] REQ_READZ = 3'd2;
   localparam logic [2:0] REQ_READS = 3'd3;
   localparam logic [2:0] REQ_RESET = 3'd4;

   localparam logic [3:0] G_I     = 4'd0;
   localparam logic [3:0] G_H     = 4'd1;
   localparam logic [3:0] G_S     = 4'd2;
   localparam logic [3:0] G_Z     = 4'd3;
   localparam logic [3:0] G_X     = 4'd4;
   localparam logic [3:0] G_Y     = 4'd5;
   localparam logic [3:0] G_SDG   = 4'd6;
   localparam logic [3:0] G_SWAP  = 4'd7;
   localparam logic [3:0] G_ISWAP = 4'd8;
   localparam logic [3:0] G_CX    = 4'd9;
   localparam logic [3:0] G_CZ    = 4'd10;
   localparam logic [3:0] G_CY    = 4'd11;

   typedef struct packed {
      word_type xa;
      word_type za;
      word_type xb;
      word_type zb;
      word_type sg;
   } gate_word_type;

endpackage

>>> rtl/core/stge_gate_alu.sv
// ----------------------------------------------------------------------------
// stge_gate_alu: per-word Clifford update of two column pairs and the signs
// ----------------------------------------------------------------------------
module stge_gate_alu
   import stge_pkg::*;
(
   input  logic [3:0]    kind,
   input  gate_word_type din,
   output gate_word_type dout
);

   always_comb begin
      word_type xa, za, xb, zb, s, t;
      xa = din.xa; za = din.za; xb = din.xb; zb = din.zb; s = din.sg;
      t = '0;
      case (kind)
         G_H: begin
            s = s ^ (xa & za); t = xa; xa = za; za = t;
         end
         G_S: begin
            s = s ^ (xa & za); za = za ^ xa;
         end
         G_SDG: begin
            s = s ^ (xa & ~za); za = za ^ xa;
         end
         G_Z: s = s ^ xa;
         G_X: s = s ^ za;
         G_Y: s = s ^ xa ^ za;
         G_SWAP: begin
            t = xa; xa = xb; xb = t; t = za; za = zb; zb = t;
         end
         G_ISWAP: begin
            t = xa; xa = xb; xb = t; t = za; za = zb; zb = t;
            s = s ^ (xa & xb & (za ^ zb));
            t = za ^ xb; zb = zb ^ xa; za = t;
            s = s ^ (xa & za); za = za ^ xa;
            s = s ^ (xb & zb); zb = zb ^ xb;
         end
         G_CX: begin
            s = s ^ (xa & zb & ~(xb ^ za)); za = za ^ zb; xb = xb ^ xa;
         end
         G_CZ: begin
            s = s ^ (xa & xb & (za ^ zb)); t = za ^ xb; zb = zb ^ xa; za = t;
         end
         G_CY: begin
            s = s ^ (xb & ~zb); zb = zb ^ xb;
            s = s ^ (xa & zb & ~(xb ^ za)); za = za ^ zb; xb = xb ^ xa;
            s = s ^ (xb & zb); zb = zb ^ xb;
         end
         default: ;
      endcase
      dout.xa = xa; dout.za = za; dout.xb = xb; dout.zb = zb; dout.sg = s;
   end

endmodule

>>> rtl/core/stabilizer_tableau_gate_engine.sv
// ----------------------------------------------------------------------------
// stabilizer_tableau_gate_engine: bit-packed stabilizer tableau, Clifford gates
// ----------------------------------------------------------------------------
// One item at a time; busy is high while it is at work. After reset, and after
// a reset request, a clearing pass rewrites the column memory to the identity.
// A gate walks ceil(qubits_in_use/64) words; each one is read, then modified
// and written back through the two memory ports. The result appears in the
// same cycle that busy falls, for exactly one cycle with rsp_valid; it cannot
// be held.
module stabilizer_tableau_gate_engine
   import stge_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_req_type,
   input  logic [3:0]           req_gate_kind,
   input  logic [7:0]           req_qubit_a,
   input  logic [7:0]           req_qubit_b,
   input  logic [1:0]           req_word_index,
   output logic                 rsp_valid,
   output logic [WordBits-1:0]  rsp_read_word,
   output logic                 rsp_status,
   input  logic                 csr_we,
   input  logic [8:0]           csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_DEC   = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_WR    = 3'd4;
   localparam logic [2:0] ST_RDW   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // X and Z column memory, one entry per (qubit, word)
   logic [2*WordBits-1:0] cmem [MaxQubits*WordsPerColumn];
   word_type              sign_ff [WordsPerColumn];

   logic [2:0]           state_ff, state_in;
   logic [CountBits-1:0] nq_ff;
   logic [2:0]           req_ff;
   logic [3:0]           kind_ff;
   logic [7:0]           qa_ff, qb_ff;
   logic [1:0]           wi_ff;
   logic [AddrBits-1:0]  clr_ff;
   logic [WordIdxBits:0] w_ff;
   logic                 status_ff;
   logic [2*WordBits-1:0] rda_ff, rdb_ff;

   logic [CountBits-1:0] cfg_val;
   logic [WordIdxBits:0] nwords;
   logic                 one_q, two_q, a_bad, b_bad;
   gate_word_type        alu_in, alu_out;
   logic [WordIdxBits-1:0] w_cur;

   always_comb begin
      cfg_val = csr_wdata;
      if (cfg_val == '0) cfg_val = CountBits'(1);
      if (cfg_val > CountBits'(MaxQubits)) cfg_val = CountBits'(MaxQubits);
   end

   assign nwords = (WordIdxBits+1)'((nq_ff + CountBits'(WordBits-1)) >> $clog2(WordBits));
   assign one_q  = (kind_ff >= G_H) && (kind_ff <= G_SDG);
   assign two_q  = (kind_ff >= G_SWAP) && (kind_ff <= G_CY);
   assign a_bad  = {1'b0, qa_ff} >= nq_ff;
   assign b_bad  = {1'b0, qb_ff} >= nq_ff;
   assign w_cur  = w_ff[WordIdxBits-1:0];
   assign busy   = state_ff != ST_IDLE;

   assign alu_in.xa = rda_ff[2*WordBits-1:WordBits];
   assign alu_in.za = rda_ff[WordBits-1:0];
   assign alu_in.xb = rdb_ff[2*WordBits-1:WordBits];
   assign alu_in.zb = rdb_ff[WordBits-1:0];
   assign alu_in.sg = sign_ff[w_cur];

   stge_gate_alu u_alu (.kind(kind_ff), .din(alu_in), .dout(alu_out));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = (req_req_type == REQ_RESET) ? ST_CLEAR : ST_DEC;
         ST_CLEAR: if (clr_ff == '1) state_in = (req_ff == REQ_RESET) ? ST_DONE : ST_IDLE;
         ST_DEC: begin
            if (req_ff == REQ_GATE) begin
               if (((one_q || two_q) && a_bad) || (two_q && b_bad)
                   || !(one_q || two_q) || (two_q && qa_ff == qb_ff)) state_in = ST_DONE;
               else state_in = ST_RD;
            end else if (req_ff == REQ_READX || req_ff == REQ_READZ) begin
               state_in = (a_bad || {1'b0, wi_ff} >= nwords) ? ST_DONE : ST_RDW;
            end else if (req_ff == REQ_READS) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD:    state_in = ST_WR;
         ST_WR:    state_in = (w_ff + 1'b1 >= nwords) ? ST_DONE : ST_RD;
         ST_RDW:   state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         nq_ff     <= CountBits'(MaxQubits);
         clr_ff    <= '0;
         req_ff    <= REQ_GATE;
         rsp_valid <= 1'b0;
         for (int i = 0; i < WordsPerColumn; i++) sign_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= state_ff == ST_DONE;
         if (csr_we) nq_ff <= cfg_val;
         if (state_ff == ST_IDLE && start) begin
            req_ff <= req_req_type; kind_ff <= req_gate_kind;
            qa_ff <= req_qubit_a; qb_ff <= req_qubit_b; wi_ff <= req_word_index;
            clr_ff <= '0; w_ff <= '0; status_ff <= 1'b0;
            rsp_read_word <= '0;
            if (req_req_type == REQ_RESET)
               for (int i = 0; i < WordsPerColumn; i++) sign_ff[i] <= '0;
         end
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DEC) begin
            if (req_ff == REQ_GATE)
               status_ff <= ((one_q || two_q) && a_bad) || (two_q && b_bad);
            else if (req_ff == REQ_READX || req_ff == REQ_READZ)
               status_ff <= a_bad || {1'b0, wi_ff} >= nwords;
            else if (req_ff == REQ_READS) begin
               status_ff <= {1'b0, wi_ff} >= nwords;
               if (!({1'b0, wi_ff} >= nwords)) rsp_read_word <= sign_ff[wi_ff];
            end
         end
         if (state_ff == ST_WR) begin
            sign_ff[w_cur] <= alu_out.sg;
            w_ff <= w_ff + 1'b1;
         end
         if (state_ff == ST_DONE && (req_ff == REQ_READX || req_ff == REQ_READZ)
             && !status_ff)
            rsp_read_word <= (req_ff == REQ_READX) ? rda_ff[2*WordBits-1:WordBits]
                                                   : rda_ff[WordBits-1:0];
      end
   end

   assign rsp_status = status_ff;

   // Memory ports: clearing pass, read of a/b words, write back
   logic [AddrBits-1:0] addr_a, addr_b;
   logic                 clr_hit;
   logic [2*WordBits-1:0] clr_data;

   assign addr_a  = (state_ff == ST_RDW || state_ff == ST_DEC) ? {qa_ff, wi_ff} : {qa_ff, w_cur};
   assign addr_b  = {qb_ff, w_cur};
   assign clr_hit = clr_ff[WordIdxBits-1:0] == clr_ff[AddrBits-1 -: WordIdxBits];
   assign clr_data = {{WordBits{1'b0}},
                      clr_hit ? (word_type'(1) << clr_ff[AddrBits-1:WordIdxBits]
                                 % WordBits) : word_type'(0)};

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         cmem[clr_ff] <= clr_data;
      end else if (state_ff == ST_WR) begin
         cmem[addr_a] <= {alu_out.xa, alu_out.za};
         // write the second column only for two-qubit gates
         if (two_q) cmem[addr_b] <= {alu_out.xb, alu_out.zb};
      end
      rda_ff <= cmem[addr_a];
      rdb_ff <= cmem[addr_b];
   end

   a_resp_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid) else $error("missing response");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("response outside idle");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR |-> w_ff < nwords) else $error("word walk overrun");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stabilizer tableau gate engine
// ----------------------------------------------------------------------------
// Drives gate, read, reset and malformed items through the start/busy port.
// A tableau predictor in the bench tracks the X and Z columns and the sign
// words, and works out the word and status of every accepted item. A checker
// compares each strobed response in order. The qubit count register is swept
// through several settings, the clamped extremes among them.
// ----------------------------------------------------------------------------
module testbench;
   import stge_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 20000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_req_type = '0;
   logic [3:0] req_gate_kind = '0;
   logic [7:0] req_qubit_a = '0;
   logic [7:0] req_qubit_b = '0;
   logic [1:0] req_word_index = '0;
   logic       rsp_valid;
   word_type   rsp_read_word;
   logic       rsp_status;
   logic       csr_we = 1'b0;
   logic [8:0] csr_wdata = '0;

   stabilizer_tableau_gate_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_req_type(req_req_type), .req_gate_kind(req_gate_kind),
      .req_qubit_a(req_qubit_a), .req_qubit_b(req_qubit_b),
      .req_word_index(req_word_index), .rsp_valid(rsp_valid),
      .rsp_read_word(rsp_read_word), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tableau copy held by the predictor
   word_type x_col [MaxQubits][WordsPerColumn];
   word_type z_col [MaxQubits][WordsPerColumn];
   word_type sign_word [WordsPerColumn];
   int unsigned qubit_count;

   word_type   pending_word [$];
   logic       pending_status [$];
   int         n_errors = 0;
   int         n_checked = 0;
   int         n_sent = 0;
   int         n_gates = 0;
   int         n_reads = 0;
   int         n_refused = 0;
   bit         allow_idle = 1'b1;
   int         stall_count = 0;

   function automatic void load_identity();
      for (int q = 0; q < MaxQubits; q++)
         for (int w = 0; w < WordsPerColumn; w++) begin
            x_col[q][w] = '0;
            z_col[q][w] = (q / WordBits == w) ? word_type'(1) << (q % WordBits) : '0;
         end
      for (int w = 0; w < WordsPerColumn; w++) sign_word[w] = '0;
   endfunction

   function automatic void phase_s(int q, int w);
      sign_word[w] ^= x_col[q][w] & z_col[q][w];
      z_col[q][w] ^= x_col[q][w];
   endfunction

   function automatic void phase_sdg(int q, int w);
      sign_word[w] ^= x_col[q][w] & ~z_col[q][w];
      z_col[q][w] ^= x_col[q][w];
   endfunction

   function automatic void flip_cx(int c, int t, int w);
      word_type xc, xt, zc, zt;
      xc = x_col[c][w]; xt = x_col[t][w]; zc = z_col[c][w]; zt = z_col[t][w];
      sign_word[w] ^= xc & zt & ~(xt ^ zc);
      z_col[c][w] = zc ^ zt;
      x_col[t][w] = xt ^ xc;
   endfunction

   function automatic void flip_cz(int c, int t, int w);
      word_type xc, xt, zc, zt;
      xc = x_col[c][w]; xt = x_col[t][w]; zc = z_col[c][w]; zt = z_col[t][w];
      sign_word[w] ^= xc & xt & (zc ^ zt);
      z_col[c][w] = zc ^ xt;
      z_col[t][w] = zt ^ xc;
   endfunction

   function automatic void swap_cols(int a, int b, int w);
      word_type tmp;
      tmp = x_col[a][w]; x_col[a][w] = x_col[b][w]; x_col[b][w] = tmp;
      tmp = z_col[a][w]; z_col[a][w] = z_col[b][w]; z_col[b][w] = tmp;
   endfunction

   function automatic int unsigned words_walked();
      int unsigned n;
      n = (qubit_count + WordBits - 1) / WordBits;
      return (n > WordsPerColumn) ? WordsPerColumn : n;
   endfunction

   // update the tableau copy and queue the response of one accepted item
   function automatic void predict_tableau(logic [2:0] rt, logic [3:0] gk,
                                           logic [7:0] qa, logic [7:0] qb,
                                           logic [1:0] wi);
      word_type    rd;
      logic        st;
      bit          one_q, two_q;
      int unsigned nw;
      word_type    tmp;
      rd = '0;
      st = 1'b0;
      nw = words_walked();
      one_q = (gk >= G_H) && (gk <= G_SDG);
      two_q = (gk >= G_SWAP) && (gk <= G_CY);
      case (rt)
         REQ_GATE: begin
            n_gates++;
            if ((one_q || two_q) && qa >= qubit_count) st = 1'b1;
            else if (two_q && qb >= qubit_count) st = 1'b1;
            else if (!(two_q && qa == qb) && (one_q || two_q)) begin
               for (int w = 0; w < nw; w++) begin
                  case (gk)
                     G_H: begin
                        sign_word[w] ^= x_col[qa][w] & z_col[qa][w];
                        tmp = x_col[qa][w];
                        x_col[qa][w] = z_col[qa][w];
                        z_col[qa][w] = tmp;
                     end
                     G_S:   phase_s(qa, w);
                     G_Z:   sign_word[w] ^= x_col[qa][w];
                     G_X:   sign_word[w] ^= z_col[qa][w];
                     G_Y:   sign_word[w] ^= x_col[qa][w] ^ z_col[qa][w];
                     G_SDG: phase_sdg(qa, w);
                     G_SWAP: swap_cols(qa, qb, w);
                     G_ISWAP: begin
                        swap_cols(qa, qb, w);
                        flip_cz(qa, qb, w);
                        phase_s(qa, w);
                        phase_s(qb, w);
                     end
                     G_CX: flip_cx(qa, qb, w);
                     G_CZ: flip_cz(qa, qb, w);
                     default: begin
                        phase_sdg(qb, w);
                        flip_cx(qa, qb, w);
                        phase_s(qb, w);
                     end
                  endcase
               end
            end
         end
         REQ_READX, REQ_READZ: begin
            n_reads++;
            if (qa >= qubit_count || wi >= nw) st = 1'b1;
            else rd = (rt == REQ_READX) ? x_col[qa][wi] : z_col[qa][wi];
         end
         REQ_READS: begin
            n_reads++;
            if (wi >= nw) st = 1'b1;
            else rd = sign_word[wi];
         end
         REQ_RESET: load_identity();
         default: ;
      endcase
      if (st) n_refused++;
      pending_word.push_back(rd);
      pending_status.push_back(st);
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_word.size() == 0) begin
            n_errors++;
            $display("%0t: response with nothing pending: expected none, actual word %h status %0d",
                     $time, rsp_read_word, rsp_status);
         end else begin
            if (rsp_read_word !== pending_word[0]) begin
               n_errors++;
               $display("%0t: read_word expected %h actual %h",
                        $time, pending_word[0], rsp_read_word);
            end
            if (rsp_status !== pending_status[0]) begin
               n_errors++;
               $display("%0t: status expected %0d actual %0d",
                        $time, pending_status[0], rsp_status);
            end
            void'(pending_word.pop_front());
            void'(pending_status.pop_front());
            n_checked++;
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_item(input logic [2:0] rt, input logic [3:0] gk,
                            input logic [7:0] qa, input logic [7:0] qb,
                            input logic [1:0] wi);
      if (allow_idle && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_req_type <= rt;
      req_gate_kind <= gk;
      req_qubit_a <= qa;
      req_qubit_b <= qb;
      req_word_index <= wi;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_tableau(rt, gk, qa, qb, wi);
      n_sent++;
   endtask

   // hold off until every response is in and the engine is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_word.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_qubit_count(input logic [8:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      qubit_count = (value == 0) ? 1 : (value > MaxQubits) ? MaxQubits : value;
   endtask

   task automatic test_directed();
      set_qubit_count(9'd256);
      send_item(REQ_GATE, G_H, 8'd0, 8'd0, 2'd0);
      send_item(REQ_GATE, G_S, 8'd0, 8'd0, 2'd0);
      send_item(REQ_GATE, G_SDG, 8'd255, 8'd0, 2'd0);
      send_item(REQ_GATE, G_H, 8'd255, 8'd0, 2'd0);
      send_item(REQ_GATE, G_SDG, 8'd255, 8'd0, 2'd0);
      send_item(REQ_GATE, G_Z, 8'd0, 8'd0, 2'd0);
      send_item(REQ_GATE, G_X, 8'd1, 8'd0, 2'd0);
      send_item(REQ_GATE, G_Y, 8'd0, 8'd0, 2'd0);
      send_item(REQ_GATE, G_I, 8'd3, 8'd0, 2'd0);
      send_item(REQ_GATE, G_SWAP, 8'd0, 8'd130, 2'd0);
      send_item(REQ_GATE, G_ISWAP, 8'd130, 8'd255, 2'd0);
      send_item(REQ_GATE, G_CX, 8'd255, 8'd64, 2'd0);
      send_item(REQ_GATE, G_CZ, 8'd64, 8'd0, 2'd0);
      send_item(REQ_GATE, G_CY, 8'd0, 8'd255, 2'd0);
      send_item(REQ_GATE, G_CX, 8'd7, 8'd7, 2'd0);
      send_item(REQ_GATE, 4'd15, 8'd200, 8'd9, 2'd0);
      send_item(3'd7, 4'd15, 8'd255, 8'd255, 2'd3);
      send_item(REQ_READX, G_I, 8'd255, 8'd0, 2'd3);
      send_item(REQ_READZ, G_I, 8'd0, 8'd0, 2'd0);
      send_item(REQ_READS, G_I, 8'd0, 8'd0, 2'd3);
      send_item(REQ_RESET, G_I, 8'd0, 8'd0, 2'd0);
      send_item(REQ_READZ, G_I, 8'd130, 8'd0, 2'd2);
      // refused items under a small qubit count
      set_qubit_count(9'd10);
      send_item(REQ_GATE, G_H, 8'd10, 8'd0, 2'd0);
      send_item(REQ_GATE, G_CZ, 8'd2, 8'd200, 2'd0);
      send_item(REQ_READX, G_I, 8'd3, 8'd0, 2'd1);
      send_item(REQ_READS, G_I, 8'd0, 8'd0, 2'd2);
   endtask

   task automatic send_random_item();
      int unsigned pick, nw;
      logic [3:0]  gk;
      pick = $urandom_range(99);
      nw = words_walked();
      if (pick < 55) begin
         gk = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                        : 4'($urandom_range(G_H, G_CY));
         send_item(REQ_GATE, gk, 8'($urandom_range(qubit_count - 1)),
                   8'($urandom_range(qubit_count - 1)), 2'($urandom_range(3)));
      end else if (pick < 82) begin
         send_item(3'($urandom_range(REQ_READX, REQ_READS)), 4'($urandom_range(15)),
                   8'($urandom_range(qubit_count - 1)), 8'($urandom_range(255)),
                   2'($urandom_range(nw - 1)));
      end else if (pick < 84) begin
         send_item(REQ_RESET, 4'($urandom_range(15)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 2'($urandom_range(3)));
      end else begin
         send_item(3'($urandom_range(7)), 4'($urandom_range(15)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   2'($urandom_range(3)));
      end
   endtask

   task automatic test_random_sweep();
      logic [8:0] counts [10] = '{9'd256, 9'd1, 9'd65, 9'd130, 9'd200,
                                  9'd0, 9'd511, 9'd64, 9'd3, 9'd256};
      for (int p = 0; p < 10; p++) begin
         set_qubit_count(counts[p]);
         allow_idle = (p != 3);
         for (int i = 0; i < 163; i++) send_random_item();
      end
      allow_idle = 1'b1;
   endtask

   initial begin
      load_identity();
      qubit_count = 256;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sweep();
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d items (%0d gates, %0d reads, %0d refused), checked %0d responses",
               n_sent, n_gates, n_reads, n_refused, n_checked);
      $display("Qubit count swept from clamped minimum to clamped maximum");
      if (n_errors == 0 && pending_word.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> stabilizer_tableau_gate_engine.f
rtl/core/stge_pkg.sv
rtl/core/stge_gate_alu.sv
rtl/core/stabilizer_tableau_gate_engine.sv
sim/testbench.sv
